FILE: rtl/infix_to_postfix_converter_defines.svh
// ----------------------------------------------------------------------------
// Infix to postfix converter assertion macros
// Shared concurrent assertion forms for the converter's RTL checks.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ITP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helpers shared by the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [2:0]       entry_t;
  typedef logic [CNT_W-1:0] count_t;

  // Token kinds on the input side
  localparam logic [2:0] FUNC_NUMBER   = 3'd0;
  localparam logic [2:0] FUNC_VARIABLE = 3'd1;
  localparam logic [2:0] FUNC_LPAREN   = 3'd2;
  localparam logic [2:0] FUNC_RPAREN   = 3'd3;
  localparam logic [2:0] FUNC_OPERATOR = 3'd4;
  localparam logic [2:0] FUNC_END      = 3'd5;

  // Operator codes; a left paren is stacked as PAREN_MARK
  localparam logic [2:0] OP_PLUS    = 3'd0;
  localparam logic [2:0] OP_MINUS   = 3'd1;
  localparam logic [2:0] OP_TIMES   = 3'd2;
  localparam logic [2:0] OP_DIVIDE  = 3'd3;
  localparam logic [2:0] OP_POWER   = 3'd4;
  localparam logic [2:0] PAREN_MARK = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_NUMBER   = 2'd0;
  localparam logic [1:0] KIND_VARIABLE = 2'd1;
  localparam logic [1:0] KIND_OPERATOR = 2'd2;
  localparam logic [1:0] KIND_END      = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  op_code;
    logic [31:0] operand;
  } tok_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [2:0]  out_op;
    logic [31:0] out_operand;
    logic        last;
    logic [1:0]  error;
  } rpn_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    entry_t push_data;
  } stk_cmd_t;

  typedef struct packed {
    entry_t top;
    entry_t next;
    count_t count;
  } stk_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic [1:0] prec_of(input entry_t op);
    logic [1:0] p;
    if (op == OP_PLUS || op == OP_MINUS) begin
      p = 2'd1;
    end else if (op == OP_TIMES || op == OP_DIVIDE) begin
      p = 2'd2;
    end else begin
      p = 2'd3;
    end
    return p;
  endfunction

endpackage

FILE: rtl/itp_cell.sv
// ----------------------------------------------------------------------------
// itp_cell
// One stack entry; takes its upper neighbor on push, lower one on pop.
// ----------------------------------------------------------------------------
module itp_cell (
  input  logic              clk,
  input  itp_pkg::cell_ctl_t ctl,
  input  itp_pkg::entry_t   from_above,
  input  itp_pkg::entry_t   from_below,
  output itp_pkg::entry_t   q
);
  import itp_pkg::*;

  entry_t val;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      val <= from_above;
    end else if (ctl.pop) begin
      val <= from_below;
    end
  end

  assign q = val;

endmodule

FILE: rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack built as a shifting row of cells plus an entry count.
// ----------------------------------------------------------------------------
module itp_stack (
  input  logic                clk,
  input  logic                rst,
  input  itp_pkg::stk_cmd_t   cmd,
  output itp_pkg::stk_stat_t  stat
);
  import itp_pkg::*;

  entry_t    cell_q [STACK_DEPTH];
  cell_ctl_t ctl;
  count_t    count;

  assign ctl.push = cmd.push;
  assign ctl.pop  = cmd.pop;

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      entry_t above;
      entry_t below;
      if (i == 0) begin : g_top
        assign above = cmd.push_data;
      end else begin : g_mid
        assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
        assign below = '0;
      end else begin : g_up
        assign below = cell_q[i+1];
      end
      itp_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .from_above (above),
        .from_below (below),
        .q          (cell_q[i])
      );
    end
  endgenerate

  // Hold the fill level; clear drops every entry at once
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + count_t'(1);
    end else if (cmd.pop) begin
      count <= count - count_t'(1);
    end
  end

  assign stat.top   = cell_q[0];
  assign stat.next  = cell_q[1];
  assign stat.count = count;

endmodule

FILE: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix token stream into postfix order.
// ----------------------------------------------------------------------------
// One token is taken per transaction on the tok channel and the postfix
// tokens leave one per transaction on the rpn channel, with last set on the
// final result of each input token. Each token is accepted and then worked
// on; number, variable, left paren and operator tokens that pop nothing,
// and a right paren that only drops its matching left paren, finish in a
// single work step. Each stacked operator popped by an operator, right paren
// or end token takes a work step of its own, because the operator stack
// shifts by one cell per cycle. Work stalls while the output register
// holds a result that the rpn side has not yet taken. The
// finished result sits in an output register, so the next token is taken
// while it waits. The stack holds STACK_DEPTH entries; a push onto a full
// stack, or a paren without its partner, yields an error result (kind end,
// last set) and empties the stack. Operator tokens with a code above
// power, and kinds above end, are dropped without any result. All
// operators, power included, associate to the left.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  output logic           tok_ready,
  input  itp_pkg::tok_t  tok,
  output logic           rpn_valid,
  input  logic           rpn_ready,
  output itp_pkg::rpn_t  rpn
);
  import itp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic      state;
  logic      state_next;
  tok_t      item;
  rpn_t      res;
  rpn_t      out_reg;
  logic      out_vld;
  logic      emit;
  logic      out_free;
  stk_cmd_t  cmd;
  stk_stat_t stat;
  logic      empty;
  logic      full;
  logic      more;
  logic      top_pops;
  logic      next_pops;

  itp_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign tok_ready = (state == S_IDLE);
  assign out_free  = !out_vld || rpn_ready;

  assign empty = (stat.count == '0);
  assign full  = (stat.count >= count_t'(STACK_DEPTH));
  // More than one entry: the cell under the top is meaningful
  assign more  = (stat.count > count_t'(1));

  // Does the stacked operator outrank (or tie) the incoming one?
  assign top_pops  = !empty && (stat.top != PAREN_MARK) &&
                     (prec_of(stat.top) >= prec_of(item.op_code));
  assign next_pops = more && (stat.next != PAREN_MARK) &&
                     (prec_of(stat.next) >= prec_of(item.op_code));

  // Latch the token on accept
  always_ff @(posedge clk) begin
    if (tok_valid && tok_ready) begin
      item <= tok;
    end
  end

  // One step of work per cycle, only when the output register can take it
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    res        = '0;
    cmd        = '0;
    if (state == S_IDLE) begin
      if (tok_valid) begin
        state_next = S_WORK;
      end
    end else if (out_free) begin
      case (item.func)
        FUNC_NUMBER, FUNC_VARIABLE: begin
          emit            = 1'b1;
          res.out_kind    = (item.func == FUNC_NUMBER) ? KIND_NUMBER : KIND_VARIABLE;
          res.out_operand = item.operand;
          res.last        = 1'b1;
          state_next      = S_IDLE;
        end
        FUNC_LPAREN: begin
          if (full) begin
            cmd.clear    = 1'b1;
            emit         = 1'b1;
            res.out_kind = KIND_END;
            res.last     = 1'b1;
            res.error    = ERR_OVERFLOW;
          end else begin
            cmd.push      = 1'b1;
            cmd.push_data = PAREN_MARK;
          end
          state_next = S_IDLE;
        end
        FUNC_RPAREN: begin
          if (empty) begin
            emit         = 1'b1;
            res.out_kind = KIND_END;
            res.last     = 1'b1;
            res.error    = ERR_PAREN;
            state_next   = S_IDLE;
          end else if (stat.top != PAREN_MARK) begin
            // Pop an operator; last only if its paren is right below
            cmd.pop      = 1'b1;
            emit         = 1'b1;
            res.out_kind = KIND_OPERATOR;
            res.out_op   = stat.top;
            res.last     = more && (stat.next == PAREN_MARK);
          end else begin
            // Drop the matching left paren
            cmd.pop    = 1'b1;
            state_next = S_IDLE;
          end
        end
        FUNC_OPERATOR: begin
          if (item.op_code > OP_POWER) begin
            state_next = S_IDLE;
          end else if (top_pops) begin
            // After a pop the push always fits, so last waits only on more pops
            cmd.pop      = 1'b1;
            emit         = 1'b1;
            res.out_kind = KIND_OPERATOR;
            res.out_op   = stat.top;
            res.last     = !next_pops;
          end else if (full) begin
            cmd.clear    = 1'b1;
            emit         = 1'b1;
            res.out_kind = KIND_END;
            res.last     = 1'b1;
            res.error    = ERR_OVERFLOW;
            state_next   = S_IDLE;
          end else begin
            cmd.push      = 1'b1;
            cmd.push_data = item.op_code;
            state_next    = S_IDLE;
          end
        end
        FUNC_END: begin
          if (empty) begin
            emit         = 1'b1;
            res.out_kind = KIND_END;
            res.last     = 1'b1;
            state_next   = S_IDLE;
          end else if (stat.top == PAREN_MARK) begin
            cmd.clear    = 1'b1;
            emit         = 1'b1;
            res.out_kind = KIND_END;
            res.last     = 1'b1;
            res.error    = ERR_PAREN;
            state_next   = S_IDLE;
          end else begin
            cmd.pop      = 1'b1;
            emit         = 1'b1;
            res.out_kind = KIND_OPERATOR;
            res.out_op   = stat.top;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: load a new result, or drop the one just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (emit) begin
      out_vld <= 1'b1;
    end else if (rpn_ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= res;
    end
  end

  assign rpn_valid = out_vld;
  assign rpn       = out_reg;

  // Checks
  `ITP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, stat.count <= count_t'(STACK_DEPTH), "stack count beyond depth")
  `ITP_ASSERT_NOW(a_pop_nonempty, clk, rst, cmd.pop, !empty && !cmd.push && !cmd.clear, "pop with empty stack or mixed command")
  `ITP_ASSERT_NOW(a_push_room, clk, rst, cmd.push, !full, "push onto full stack")
  `ITP_ASSERT_NOW(a_err_final, clk, rst, rpn_valid && (rpn.error != ERR_NONE), rpn.last && (rpn.out_kind == KIND_END), "error result not final end marker")
  `ITP_ASSERT_NEXT(a_accept_work, clk, rst, tok_valid && tok_ready, state == S_WORK && !tok_ready, "accepted token did not start work")

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: infix to postfix converter testbench
// Feeds infix tokens through the tok channel and checks every postfix result
// against an in-bench shunting-yard predictor that keeps its own operator
// stack. A directed opening covers all token kinds, every operator,
// precedence and left associativity, paren errors and dropped tokens.
// Random well-formed expressions, stack-filling runs and noise follow, under
// three idling phases on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int RANDOM_ITEMS = 130;
  localparam int DRAIN_CYCLES = 80;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  tok_valid = 1'b0;
  logic  tok_ready;
  tok_t  tok = '0;
  logic  rpn_valid;
  logic  rpn_ready = 1'b0;
  rpn_t  rpn;

  // Tokens waiting to be driven, and the postfix results still owed by the DUT
  tok_t  tok_q[$];
  rpn_t  postfix_q[$];

  // Predictor state: operator stack and its fill level
  logic [2:0]  op_stk[STACK_DEPTH];
  int unsigned op_depth = 0;

  int    accepted_cnt = 0;
  int    total_toks = 1;
  int    live_cnt = 0;
  bit    failed = 1'b0;

  infix_to_postfix_converter dut (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .rpn_valid (rpn_valid),
    .rpn_ready (rpn_ready),
    .rpn       (rpn)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hung run
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int op_rank(input logic [2:0] op);
    int r;
    if (op == OP_PLUS || op == OP_MINUS) begin
      r = 1;
    end else if (op == OP_TIMES || op == OP_DIVIDE) begin
      r = 2;
    end else begin
      r = 3;
    end
    return r;
  endfunction

  function automatic rpn_t make_rpn(input logic [1:0] kind, input logic [2:0] op,
                                    input logic [31:0] val, input logic [1:0] err);
    rpn_t r;
    r.out_kind    = kind;
    r.out_op      = op;
    r.out_operand = val;
    r.last        = 1'b0;
    r.error       = err;
    return r;
  endfunction

  // Advance the predicted stack by one token and queue the postfix results
  // it releases; the final one of the token carries last.
  function automatic void convert_token(input tok_t t);
    rpn_t step[$];
    bit   open_paren;
    case (t.func)
      FUNC_NUMBER: begin
        step.insert(step.size(), make_rpn(KIND_NUMBER, '0, t.operand, ERR_NONE));
      end
      FUNC_VARIABLE: begin
        step.insert(step.size(), make_rpn(KIND_VARIABLE, '0, t.operand, ERR_NONE));
      end
      FUNC_LPAREN: begin
        if (op_depth >= STACK_DEPTH) begin
          op_depth = 0;
          step.insert(step.size(), make_rpn(KIND_END, '0, '0, ERR_OVERFLOW));
        end else begin
          op_stk[op_depth] = PAREN_MARK;
          op_depth++;
        end
      end
      FUNC_RPAREN: begin
        // Release operators down to the partner paren, then drop it
        while (op_depth > 0 && op_stk[op_depth-1] != PAREN_MARK) begin
          op_depth--;
          step.insert(step.size(),
                      make_rpn(KIND_OPERATOR, op_stk[op_depth], '0, ERR_NONE));
        end
        if (op_depth == 0) begin
          step.insert(step.size(), make_rpn(KIND_END, '0, '0, ERR_PAREN));
        end else begin
          op_depth--;
        end
      end
      FUNC_OPERATOR: begin
        if (t.op_code <= OP_POWER) begin
          // Left associative for every operator: equal rank pops too
          while (op_depth > 0 && op_stk[op_depth-1] != PAREN_MARK &&
                 op_rank(op_stk[op_depth-1]) >= op_rank(t.op_code)) begin
            op_depth--;
            step.insert(step.size(),
                        make_rpn(KIND_OPERATOR, op_stk[op_depth], '0, ERR_NONE));
          end
          if (op_depth >= STACK_DEPTH) begin
            op_depth = 0;
            step.insert(step.size(), make_rpn(KIND_END, '0, '0, ERR_OVERFLOW));
          end else begin
            op_stk[op_depth] = t.op_code;
            op_depth++;
          end
        end
      end
      FUNC_END: begin
        // Flush; an open paren turns the end marker into a paren error
        open_paren = 1'b0;
        while (op_depth > 0 && !open_paren) begin
          op_depth--;
          if (op_stk[op_depth] == PAREN_MARK) begin
            open_paren = 1'b1;
            op_depth = 0;
          end else begin
            step.insert(step.size(),
                        make_rpn(KIND_OPERATOR, op_stk[op_depth], '0, ERR_NONE));
          end
        end
        step.insert(step.size(),
                    make_rpn(KIND_END, '0, '0, open_paren ? ERR_PAREN : ERR_NONE));
      end
      default: begin
      end
    endcase
    if (step.size() > 0) begin
      step[step.size()-1].last = 1'b1;
    end
    postfix_q = {postfix_q, step};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  function automatic void queue_token(input logic [2:0] func, input logic [2:0] op,
                                      input logic [31:0] val);
    tok_t t;
    t.func    = func;
    t.op_code = op;
    t.operand = val;
    tok_q.insert(tok_q.size(), t);
    // Dropped tokens do not count toward the item budget
    if (func <= FUNC_END && !(func == FUNC_OPERATOR && op > OP_POWER)) begin
      live_cnt++;
    end
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = '1;
      1:       w = '0;
      2:       w = $urandom_range(0, 15);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic void queue_operand();
    queue_token($urandom_range(0, 1) ? FUNC_VARIABLE : FUNC_NUMBER, '0, rand_word());
  endfunction

  function automatic void queue_operator();
    queue_token(FUNC_OPERATOR, 3'($urandom_range(OP_PLUS, OP_POWER)), '0);
  endfunction

  // Well-formed expression with random nesting; sometimes broken on purpose
  function automatic void gen_expression();
    int terms;
    int open;
    int flaw;
    terms = $urandom_range(1, 7);
    open  = 0;
    flaw  = $urandom_range(0, 99);
    for (int k = 0; k < terms; k++) begin
      while (open < 6 && $urandom_range(0, 3) == 0) begin
        queue_token(FUNC_LPAREN, '0, '0);
        open++;
      end
      queue_operand();
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        queue_token(FUNC_RPAREN, '0, '0);
        open--;
      end
      if (k < terms - 1) queue_operator();
    end
    // Leave one paren open, or add a stray closing one
    if (flaw < 8 && open > 0) open--;
    if (flaw >= 8 && flaw < 14) queue_token(FUNC_RPAREN, '0, '0);
    repeat (open) queue_token(FUNC_RPAREN, '0, '0);
    // Most expressions close; the rest run into the next one
    if (flaw < 90) queue_token(FUNC_END, '0, '0);
  endfunction

  // Fill the stack to the top and push once more
  function automatic void gen_overflow();
    case ($urandom_range(0, 2))
      0: begin
        repeat (STACK_DEPTH + 1) queue_token(FUNC_LPAREN, '0, '0);
      end
      1: begin
        for (int k = 0; k < STACK_DEPTH / 2; k++) begin
          queue_token(FUNC_LPAREN, '0, '0);
          queue_operand();
          queue_operator();
        end
        if ($urandom_range(0, 1)) begin
          queue_token(FUNC_LPAREN, '0, '0);
        end else begin
          queue_operand();
          queue_operator();
        end
      end
      default: begin
        // Low-rank operator on top of a full stack blocks a higher one
        repeat (STACK_DEPTH - 1) queue_token(FUNC_LPAREN, '0, '0);
        queue_operand();
        queue_token(FUNC_OPERATOR, 3'($urandom_range(OP_PLUS, OP_MINUS)), '0);
        queue_operand();
        queue_token(FUNC_OPERATOR, 3'($urandom_range(OP_TIMES, OP_POWER)), '0);
      end
    endcase
    queue_token(FUNC_END, '0, '0);
  endfunction

  function automatic void gen_noise();
    repeat ($urandom_range(1, 4)) begin
      queue_token(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
    end
  endfunction

  function automatic void build_directed();
    // a + b * c ^ d ^ e - ( f / g ) end: all operators, rank order,
    // power taken left to right, paren matched
    queue_token(FUNC_NUMBER,   '0,        32'h0000_0000);
    queue_token(FUNC_OPERATOR, OP_PLUS,   '0);
    queue_token(FUNC_VARIABLE, '0,        32'hFFFF_FFFF);
    queue_token(FUNC_OPERATOR, OP_TIMES,  '0);
    queue_token(FUNC_NUMBER,   '0,        32'h5A5A_5A5A);
    queue_token(FUNC_OPERATOR, OP_POWER,  '0);
    queue_token(FUNC_VARIABLE, '0,        32'hA5A5_A5A5);
    queue_token(FUNC_OPERATOR, OP_POWER,  '0);
    queue_token(FUNC_NUMBER,   '0,        32'h8000_0001);
    queue_token(FUNC_OPERATOR, OP_MINUS,  '0);
    queue_token(FUNC_LPAREN,   '0,        '0);
    queue_token(FUNC_VARIABLE, '0,        32'h0000_0007);
    queue_token(FUNC_OPERATOR, OP_DIVIDE, '0);
    queue_token(FUNC_NUMBER,   '0,        32'h7FFF_FFFE);
    queue_token(FUNC_RPAREN,   '0,        '0);
    queue_token(FUNC_END,      '0,        '0);
    // Closing paren on an empty stack
    queue_token(FUNC_RPAREN,   '0,        '0);
    // Paren still open at end
    queue_token(FUNC_LPAREN,   '0,        '0);
    queue_token(FUNC_NUMBER,   '0,        32'h0000_0001);
    queue_token(FUNC_OPERATOR, OP_PLUS,   '0);
    queue_token(FUNC_END,      '0,        '0);
    // Dropped tokens: bad operator code and the unused kinds
    queue_token(FUNC_OPERATOR, 3'd7,      32'hFFFF_FFFF);
    queue_token(FUNC_OPERATOR, 3'd5,      '0);
    queue_token(3'd6,          3'd7,      32'hFFFF_FFFF);
    queue_token(3'd7,          3'd2,      32'h1234_5678);
    // Closing paren with only an operator below it
    queue_token(FUNC_OPERATOR, OP_MINUS,  '0);
    queue_token(FUNC_RPAREN,   '0,        '0);
  endfunction

  // --------------------------------------------------------------------------
  // Idling: phase 0 sender 8% / receiver 68%, phase 1 swapped, phase 2 none
  // --------------------------------------------------------------------------

  function automatic int run_phase();
    return (accepted_cnt * 3) / total_toks;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued tokens, predict each one as it is accepted
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    int  send_idle;
    bit  advance;
    send_idle = (run_phase() == 0) ? 8 : (run_phase() == 1) ? 68 : 0;
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      advance = !tok_valid;
      if (tok_valid && tok_ready) begin
        convert_token(tok);
        accepted_cnt++;
        advance = 1'b1;
      end
      // Hold valid and payload until the transaction completes
      if (advance) begin
        if (tok_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          tok       <= tok_q[0];
          tok_valid <= 1'b1;
          tok_q.delete(0);
        end else begin
          tok_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: throttle rpn_ready and check every accepted result in order
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp != act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    int   recv_idle;
    rpn_t exp;
    recv_idle = (run_phase() == 0) ? 68 : (run_phase() == 1) ? 8 : 0;
    if (rst) begin
      rpn_ready <= 1'b0;
    end else begin
      if (rpn_valid && rpn_ready) begin
        if (postfix_q.size() == 0) begin
          $error("rpn: unexpected transaction, kind %0d op %0d operand %0h",
                 rpn.out_kind, rpn.out_op, rpn.out_operand);
          failed = 1'b1;
        end else begin
          exp = postfix_q[0];
          postfix_q.delete(0);
          check_field("out_kind",    32'(exp.out_kind), 32'(rpn.out_kind));
          check_field("out_op",      32'(exp.out_op),   32'(rpn.out_op));
          check_field("out_operand", exp.out_operand,   rpn.out_operand);
          check_field("last",        32'(exp.last),     32'(rpn.last));
          check_field("error",       32'(exp.error),    32'(rpn.error));
        end
      end
      rpn_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build stimulus, reset, drain, report
  // --------------------------------------------------------------------------

  initial begin
    int base;
    int pick;
    build_directed();
    base = live_cnt;
    while (live_cnt < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        gen_expression();
      end else if (pick < 82) begin
        gen_overflow();
      end else begin
        gen_noise();
      end
    end
    total_toks = tok_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every token to be taken, then for the owed results
    while (tok_q.size() != 0 || tok_valid) @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    // Give stray results a chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (postfix_q.size() != 0) begin
      $error("rpn: %0d results never arrived", postfix_q.size());
      failed = 1'b1;
    end

    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: infix_to_postfix_converter.f
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_cell.sv
rtl/itp_stack.sv
rtl/infix_to_postfix_converter.sv
bench/tb.sv
